// ===== hdl/dpsu_pkg.sv =====
// ----------------------------------------------------------------------------
// dpsu_pkg
// Shared types and constants for the detector packet sparse unpacker.
// ----------------------------------------------------------------------------
package dpsu_pkg;

    // default largest packet length in words
    localparam int MAX_PACKET_WORDS_DEF = 4096;

    // word and field geometry
    localparam int WORD_W     = 32;
    localparam int LOW_W      = 20;
    localparam int LEN_IN_W   = 13;
    localparam int SLOTS      = 4;
    localparam int SAMPLE_W   = 5;
    localparam int CHAN_W     = 6;
    localparam int TIME_HI_W  = 5;
    localparam int TIME_W     = 7;
    localparam int HDR_WORDS  = 4;
    localparam int PEND_W     = SLOTS + 1;
    localparam int END_BIT    = 31;
    localparam int CHAN_LSB   = 25;
    localparam int TIME_LSB   = 20;

    // packet layout
    localparam int MIN_PACKET_WORDS = 6;
    localparam int HDR_FIRST_POS    = 1;
    localparam int HDR_LAST_POS     = 4;
    localparam int DATA_FIRST_POS   = 5;
    localparam int USER_FROM_END    = 3;
    localparam int PARITY_FROM_END  = 2;
    localparam int LAST_FROM_END    = 1;

    // result kinds
    localparam logic KIND_HIT     = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // one decoded word waiting to be handed out as results
    typedef struct packed {
        logic [CHAN_W-1:0]                 channel;
        logic [TIME_HI_W-1:0]              time_hi;
        logic [SLOTS-1:0][SAMPLE_W-1:0]    samples;
        logic [HDR_WORDS-1:0][LOW_W-1:0]   header;
        logic [WORD_W-1:0]                 user_word;
        logic                              parity_ok;
    } t_item;

endpackage

// ===== hdl/dpsu_decode.sv =====
// ----------------------------------------------------------------------------
// dpsu_decode
// Packet word tracking and decode: keeps the packet state and registers each
// accepted word as a pending item with one pending bit per result.
// ----------------------------------------------------------------------------
module dpsu_decode #(
    parameter int MAX_PACKET_WORDS = dpsu_pkg::MAX_PACKET_WORDS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic [dpsu_pkg::WORD_W-1:0]       i_word,
    input  logic                              i_first,
    input  logic [dpsu_pkg::LEN_IN_W-1:0]     i_packet_words,
    input  logic [dpsu_pkg::PEND_W-1:0]       i_pop,
    output logic                              o_stall,
    output dpsu_pkg::t_item                   o_item,
    output logic [dpsu_pkg::PEND_W-1:0]       o_pend
);

    localparam int LW = $clog2(MAX_PACKET_WORDS + 1);
    localparam int PW = $clog2(MAX_PACKET_WORDS);
    localparam int CW = (LW > dpsu_pkg::LEN_IN_W) ? LW : dpsu_pkg::LEN_IN_W;

    // packet state
    logic                                           r_active;
    logic [PW-1:0]                                  r_pos;
    logic [LW-1:0]                                  r_len;
    logic [dpsu_pkg::LOW_W-1:0]                     r_psum;
    logic                                           r_open;
    logic [dpsu_pkg::HDR_WORDS-1:0][dpsu_pkg::LOW_W-1:0] r_hdr;
    logic [dpsu_pkg::WORD_W-1:0]                    r_user;
    logic [dpsu_pkg::WORD_W-1:0]                    r_parw;

    // pending item
    logic [dpsu_pkg::PEND_W-1:0]                    r_pend;
    dpsu_pkg::t_item                                r_item;

    logic [dpsu_pkg::PEND_W-1:0]  pend_left;
    logic                         accept;
    logic [CW-1:0]                len_ext;
    logic [LW-1:0]                len_clamp;
    logic [LW-1:0]                cur_len;
    logic [PW-1:0]                cur_pos;
    logic [LW-1:0]                pos_ext;
    logic [dpsu_pkg::LOW_W-1:0]   cur_psum;
    logic                         cur_open;
    logic                         live;
    logic [LW-1:0]                len_user;
    logic [LW-1:0]                len_par;
    logic [LW-1:0]                len_last;
    logic                         in_hdr;
    logic                         in_data;
    logic                         is_last;
    logic [1:0]                   hdr_idx;
    logic [dpsu_pkg::SLOTS-1:0]   hit_mask;
    logic                         parity_ok;

    // handshake: take a new beat once the pending item drains this cycle
    assign pend_left = r_pend & ~i_pop;
    assign o_stall   = |pend_left;
    assign accept    = i_valid && !o_stall;

    // length sampling with clamp
    assign len_ext = CW'(i_packet_words);
    always_comb begin
        if (len_ext < CW'(dpsu_pkg::MIN_PACKET_WORDS)) begin
            len_clamp = LW'(dpsu_pkg::MIN_PACKET_WORDS);
        end else if (len_ext > CW'(MAX_PACKET_WORDS)) begin
            len_clamp = LW'(MAX_PACKET_WORDS);
        end else begin
            len_clamp = LW'(len_ext);
        end
    end

    // state seen by this beat, a first word restarts the packet
    assign cur_len  = i_first ? len_clamp : r_len;
    assign cur_pos  = i_first ? '0 : r_pos;
    assign cur_psum = i_first ? '0 : r_psum;
    assign cur_open = i_first ? 1'b1 : r_open;
    assign live     = i_first || r_active;
    assign pos_ext  = LW'(cur_pos);

    assign len_user = cur_len - LW'(dpsu_pkg::USER_FROM_END);
    assign len_par  = cur_len - LW'(dpsu_pkg::PARITY_FROM_END);
    assign len_last = cur_len - LW'(dpsu_pkg::LAST_FROM_END);

    // word role decode
    assign in_hdr  = (pos_ext >= LW'(dpsu_pkg::HDR_FIRST_POS)) &&
                     (pos_ext <= LW'(dpsu_pkg::HDR_LAST_POS));
    assign in_data = live && cur_open && (pos_ext >= LW'(dpsu_pkg::DATA_FIRST_POS)) &&
                     (pos_ext < len_user);
    assign is_last = live && (pos_ext == len_last);
    assign hdr_idx = 2'(pos_ext - LW'(dpsu_pkg::HDR_FIRST_POS));

    // one hit per nonzero sample slot
    always_comb begin
        for (int s = 0; s < dpsu_pkg::SLOTS; s++) begin
            hit_mask[s] = in_data && !i_word[dpsu_pkg::END_BIT] &&
                          (i_word[s*dpsu_pkg::SAMPLE_W +: dpsu_pkg::SAMPLE_W] != '0);
        end
    end

    // running parity checked against the whole parity word
    assign parity_ok = ({{(dpsu_pkg::WORD_W-dpsu_pkg::LOW_W){1'b0}}, cur_psum} == r_parw);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_pos    <= '0;
            r_len    <= '0;
            r_psum   <= '0;
            r_open   <= 1'b0;
            r_pend   <= '0;
        end else if (accept) begin
            r_pend <= {is_last, hit_mask};
            if (live) begin
                r_len <= cur_len;
                if (pos_ext <= len_user) begin
                    r_psum <= cur_psum ^ i_word[dpsu_pkg::LOW_W-1:0];
                end else begin
                    r_psum <= cur_psum;
                end
                if (is_last) begin
                    r_active <= 1'b0;
                    r_pos    <= '0;
                    r_open   <= 1'b0;
                end else begin
                    r_active <= 1'b1;
                    r_pos    <= cur_pos + PW'(1);
                    r_open   <= cur_open && !(in_data && i_word[dpsu_pkg::END_BIT]);
                end
            end
        end else begin
            r_pend <= pend_left;
        end
    end

    // header, user and parity words
    always_ff @(posedge i_clk) begin
        if (accept && live) begin
            if (in_hdr) begin
                r_hdr[hdr_idx] <= i_word[dpsu_pkg::LOW_W-1:0];
            end
            if (pos_ext == len_user) begin
                r_user <= i_word;
            end
            if (pos_ext == len_par) begin
                r_parw <= i_word;
            end
        end
    end

    // pending item payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.channel   <= i_word[dpsu_pkg::CHAN_LSB +: dpsu_pkg::CHAN_W];
            r_item.time_hi   <= i_word[dpsu_pkg::TIME_LSB +: dpsu_pkg::TIME_HI_W];
            r_item.samples   <= i_word[dpsu_pkg::SLOTS*dpsu_pkg::SAMPLE_W-1:0];
            r_item.header    <= r_hdr;
            r_item.user_word <= r_user;
            r_item.parity_ok <= parity_ok;
        end
    end

    assign o_item = r_item;
    assign o_pend = r_pend;

endmodule

// ===== hdl/dpsu_emit.sv =====
// ----------------------------------------------------------------------------
// dpsu_emit
// Result register: hands out the pending results of one item, lowest slot
// first and the summary last, one beat per cycle unless the receiver stalls.
// ----------------------------------------------------------------------------
module dpsu_emit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_stall,
    input  dpsu_pkg::t_item                     i_item,
    input  logic [dpsu_pkg::PEND_W-1:0]         i_pend,
    output logic [dpsu_pkg::PEND_W-1:0]         o_pop,
    output logic                                o_valid,
    output logic                                o_kind,
    output logic [dpsu_pkg::CHAN_W-1:0]         o_channel,
    output logic [dpsu_pkg::TIME_W-1:0]         o_time_bin,
    output logic [dpsu_pkg::SAMPLE_W-1:0]       o_sample,
    output logic [dpsu_pkg::LOW_W-1:0]          o_event_number,
    output logic [dpsu_pkg::LOW_W-1:0]          o_module_address,
    output logic [dpsu_pkg::LOW_W-1:0]          o_flag_word,
    output logic [dpsu_pkg::LOW_W-1:0]          o_beam_clock,
    output logic [dpsu_pkg::WORD_W-1:0]         o_user_word,
    output logic                                o_parity_ok,
    output logic                                o_end_of_packet
);

    logic                               r_valid;
    logic                               r_kind;
    logic [dpsu_pkg::CHAN_W-1:0]        r_channel;
    logic [dpsu_pkg::TIME_W-1:0]        r_time_bin;
    logic [dpsu_pkg::SAMPLE_W-1:0]      r_sample;
    logic [dpsu_pkg::LOW_W-1:0]         r_event_number;
    logic [dpsu_pkg::LOW_W-1:0]         r_module_address;
    logic [dpsu_pkg::LOW_W-1:0]         r_flag_word;
    logic [dpsu_pkg::LOW_W-1:0]         r_beam_clock;
    logic [dpsu_pkg::WORD_W-1:0]        r_user_word;
    logic                               r_parity_ok;
    logic                               r_end_of_packet;

    logic                               out_free;
    logic [dpsu_pkg::PEND_W-1:0]        pick;
    logic [1:0]                         slot;
    logic                               pick_summary;

    // lowest pending result goes out when the result register is free
    assign out_free     = !r_valid || !i_stall;
    assign pick         = i_pend & (~i_pend + dpsu_pkg::PEND_W'(1));
    assign pick_summary = pick[dpsu_pkg::SLOTS];
    assign o_pop        = out_free ? pick : '0;

    // slot number of the picked hit
    always_comb begin
        if (pick[1]) begin
            slot = 2'd1;
        end else if (pick[2]) begin
            slot = 2'd2;
        end else if (pick[3]) begin
            slot = 2'd3;
        end else begin
            slot = 2'd0;
        end
    end

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (out_free) begin
            r_valid <= |i_pend;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (pick_summary) begin
                r_kind           <= dpsu_pkg::KIND_SUMMARY;
                r_channel        <= '0;
                r_time_bin       <= '0;
                r_sample         <= '0;
                r_event_number   <= i_item.header[0];
                r_module_address <= i_item.header[1];
                r_flag_word      <= i_item.header[2];
                r_beam_clock     <= i_item.header[3];
                r_user_word      <= i_item.user_word;
                r_parity_ok      <= i_item.parity_ok;
                r_end_of_packet  <= 1'b1;
            end else begin
                r_kind           <= dpsu_pkg::KIND_HIT;
                r_channel        <= i_item.channel;
                r_time_bin       <= {i_item.time_hi, slot};
                r_sample         <= i_item.samples[slot];
                r_event_number   <= '0;
                r_module_address <= '0;
                r_flag_word      <= '0;
                r_beam_clock     <= '0;
                r_user_word      <= '0;
                r_parity_ok      <= 1'b0;
                r_end_of_packet  <= 1'b0;
            end
        end
    end

    assign o_valid          = r_valid;
    assign o_kind           = r_kind;
    assign o_channel        = r_channel;
    assign o_time_bin       = r_time_bin;
    assign o_sample         = r_sample;
    assign o_event_number   = r_event_number;
    assign o_module_address = r_module_address;
    assign o_flag_word      = r_flag_word;
    assign o_beam_clock     = r_beam_clock;
    assign o_user_word      = r_user_word;
    assign o_parity_ok      = r_parity_ok;
    assign o_end_of_packet  = r_end_of_packet;

endmodule

// ===== hdl/detector_packet_sparse_unpacker.sv =====
// ----------------------------------------------------------------------------
// detector_packet_sparse_unpacker
// Unpacks sparse detector readout packets into hits and a packet summary.
// ----------------------------------------------------------------------------
// usage
//   input channel: i_valid / o_stall, one packet word per beat; i_first marks
//   word 0 and i_packet_words gives the packet length on that beat.
//   output channel: o_valid / i_stall, one result per beat: a hit for each
//   nonzero sample of a data word, then a summary on the last packet word.
//   path: an accepted word is registered as a pending item in u_decode, and
//   its results then move into the result register that drives o_valid.
//   throughput: a word holds the input until all of its results have moved
//   into the result register; words with one or no result go at one per
//   cycle while the receiver does not stall.
//   the next word is taken in the cycle in which the last pending result of
//   the current one moves into the result register.
//   when the receiver stalls, the result register holds its beat, and
//   o_stall rises as soon as a decoded word still has results waiting.
//   reset (synchronous, active low) drops the packet in progress and any
//   pending results; words before the next first word are ignored.
// ----------------------------------------------------------------------------
module detector_packet_sparse_unpacker #(
    parameter int MAX_PACKET_WORDS = dpsu_pkg::MAX_PACKET_WORDS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [dpsu_pkg::WORD_W-1:0]         i_word,
    input  logic                                i_first,
    input  logic [dpsu_pkg::LEN_IN_W-1:0]       i_packet_words,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_kind,
    output logic [dpsu_pkg::CHAN_W-1:0]         o_channel,
    output logic [dpsu_pkg::TIME_W-1:0]         o_time_bin,
    output logic [dpsu_pkg::SAMPLE_W-1:0]       o_sample,
    output logic [dpsu_pkg::LOW_W-1:0]          o_event_number,
    output logic [dpsu_pkg::LOW_W-1:0]          o_module_address,
    output logic [dpsu_pkg::LOW_W-1:0]          o_flag_word,
    output logic [dpsu_pkg::LOW_W-1:0]          o_beam_clock,
    output logic [dpsu_pkg::WORD_W-1:0]         o_user_word,
    output logic                                o_parity_ok,
    output logic                                o_end_of_packet
);

    dpsu_pkg::t_item                 item;
    logic [dpsu_pkg::PEND_W-1:0]     pend;
    logic [dpsu_pkg::PEND_W-1:0]     pop;

    // word decode and packet state
    dpsu_decode #(
        .MAX_PACKET_WORDS (MAX_PACKET_WORDS)
    ) u_decode (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_word         (i_word),
        .i_first        (i_first),
        .i_packet_words (i_packet_words),
        .i_pop          (pop),
        .o_stall        (o_stall),
        .o_item         (item),
        .o_pend         (pend)
    );

    // result register
    dpsu_emit u_emit (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_stall          (i_stall),
        .i_item           (item),
        .i_pend           (pend),
        .o_pop            (pop),
        .o_valid          (o_valid),
        .o_kind           (o_kind),
        .o_channel        (o_channel),
        .o_time_bin       (o_time_bin),
        .o_sample         (o_sample),
        .o_event_number   (o_event_number),
        .o_module_address (o_module_address),
        .o_flag_word      (o_flag_word),
        .o_beam_clock     (o_beam_clock),
        .o_user_word      (o_user_word),
        .o_parity_ok      (o_parity_ok),
        .o_end_of_packet  (o_end_of_packet)
    );

endmodule

// ===== tb/sv/tb_detector_packet_sparse_unpacker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_detector_packet_sparse_unpacker
// Self-checking bench for the sparse packet unpacker. Packets go in one word
// per beat with random gaps. A scoreboard decodes every accepted word into the
// hits and summaries it should give and compares them in order with what comes
// out under random back-pressure. A long receiver hold-off fills the block.
// ----------------------------------------------------------------------------

// one decoded result, hit or packet summary
typedef struct {
    logic                                 kind;
    logic [dpsu_pkg::CHAN_W-1:0]          channel;
    logic [dpsu_pkg::TIME_W-1:0]          time_bin;
    logic [dpsu_pkg::SAMPLE_W-1:0]        sample;
    logic [dpsu_pkg::LOW_W-1:0]           event_number;
    logic [dpsu_pkg::LOW_W-1:0]           module_address;
    logic [dpsu_pkg::LOW_W-1:0]           flag_word;
    logic [dpsu_pkg::LOW_W-1:0]           beam_clock;
    logic [dpsu_pkg::WORD_W-1:0]          user_word;
    logic                                 parity_ok;
    logic                                 end_of_packet;
} t_unpack_result;

class packet_scoreboard;
    // packet decoder state
    int unsigned                      word_pos;
    int unsigned                      len_held;
    logic [dpsu_pkg::LOW_W-1:0]       xor_acc;
    bit                               data_open;
    logic [dpsu_pkg::LOW_W-1:0]       hdr [dpsu_pkg::HDR_WORDS];
    logic [dpsu_pkg::WORD_W-1:0]      user_held;
    logic [dpsu_pkg::WORD_W-1:0]      parity_held;

    t_unpack_result                   expected_q [$];
    int unsigned                      mismatches;
    int unsigned                      checked;

    function new();
        word_pos    = 0;
        len_held    = 0;
        xor_acc     = '0;
        data_open   = 0;
        foreach (hdr[i]) hdr[i] = '0;
        user_held   = '0;
        parity_held = '0;
        mismatches  = 0;
        checked     = 0;
    endfunction

    static function int unsigned clamp_length(logic [dpsu_pkg::LEN_IN_W-1:0] plen);
        if (plen < dpsu_pkg::MIN_PACKET_WORDS) return dpsu_pkg::MIN_PACKET_WORDS;
        if (plen > dpsu_pkg::MAX_PACKET_WORDS_DEF) return dpsu_pkg::MAX_PACKET_WORDS_DEF;
        return plen;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    // decode one accepted word into the results it should give
    function void note_word(logic [31:0] w, logic first, logic [12:0] plen);
        int unsigned    pos;
        int unsigned    len;
        int unsigned    s;
        logic [4:0]     v;
        t_unpack_result r;
        if (first) begin
            len_held    = clamp_length(plen);
            word_pos    = 0;
            xor_acc     = '0;
            data_open   = 1;
            foreach (hdr[i]) hdr[i] = '0;
            user_held   = '0;
            parity_held = '0;
        end
        if (len_held == 0) return;
        pos = word_pos;
        len = len_held;

        // header words
        if (pos >= dpsu_pkg::HDR_FIRST_POS && pos <= dpsu_pkg::HDR_LAST_POS)
            hdr[pos - dpsu_pkg::HDR_FIRST_POS] = w[dpsu_pkg::LOW_W-1:0];

        // data region, closed early by the end bit
        if (pos >= dpsu_pkg::DATA_FIRST_POS && pos < len - dpsu_pkg::USER_FROM_END
                && data_open) begin
            if (w[dpsu_pkg::END_BIT]) begin
                data_open = 0;
            end else begin
                for (s = 0; s < dpsu_pkg::SLOTS; s++) begin
                    v = w[s*dpsu_pkg::SAMPLE_W +: dpsu_pkg::SAMPLE_W];
                    if (v != 0) begin
                        r = '{default: '0};
                        r.kind     = dpsu_pkg::KIND_HIT;
                        r.channel  = w[dpsu_pkg::CHAN_LSB +: dpsu_pkg::CHAN_W];
                        r.time_bin = {w[dpsu_pkg::TIME_LSB +: dpsu_pkg::TIME_HI_W], 2'b00}
                                     | s[1:0];
                        r.sample   = v;
                        expected_q.push_back(r);
                    end
                end
            end
        end

        // running parity, user and parity words
        if (pos <= len - dpsu_pkg::USER_FROM_END) xor_acc = xor_acc ^ w[dpsu_pkg::LOW_W-1:0];
        if (pos == len - dpsu_pkg::USER_FROM_END) user_held = w;
        if (pos == len - dpsu_pkg::PARITY_FROM_END) parity_held = w;

        // last word closes the packet with its summary
        if (pos == len - dpsu_pkg::LAST_FROM_END) begin
            r = '{default: '0};
            r.kind           = dpsu_pkg::KIND_SUMMARY;
            r.event_number   = hdr[0];
            r.module_address = hdr[1];
            r.flag_word      = hdr[2];
            r.beam_clock     = hdr[3];
            r.user_word      = user_held;
            r.parity_ok      = ({12'h000, xor_acc} == parity_held);
            r.end_of_packet  = 1'b1;
            expected_q.push_back(r);
            len_held  = 0;
            word_pos  = 0;
            data_open = 0;
        end else begin
            word_pos = pos + 1;
        end
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    // compare one result beat with the oldest expectation
    function void check_result(t_unpack_result got);
        t_unpack_result want;
        if (expected_q.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result, expected none, got kind %0h",
                     $time, got.kind);
            return;
        end
        want = expected_q.pop_front();
        checked++;
        compare_field("kind", want.kind, got.kind);
        compare_field("channel", want.channel, got.channel);
        compare_field("time_bin", want.time_bin, got.time_bin);
        compare_field("sample", want.sample, got.sample);
        compare_field("event_number", want.event_number, got.event_number);
        compare_field("module_address", want.module_address, got.module_address);
        compare_field("flag_word", want.flag_word, got.flag_word);
        compare_field("beam_clock", want.beam_clock, got.beam_clock);
        compare_field("user_word", want.user_word, got.user_word);
        compare_field("parity_ok", want.parity_ok, got.parity_ok);
        compare_field("end_of_packet", want.end_of_packet, got.end_of_packet);
    endfunction
endclass

module tb_detector_packet_sparse_unpacker;

    localparam int TARGET_WORDS = 330;
    localparam int HOLD_CYCLES  = 400;
    localparam int STUCK_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 20;

    logic                                 i_clk;
    logic                                 i_rst_n;
    logic                                 i_valid;
    logic                                 o_stall;
    logic [dpsu_pkg::WORD_W-1:0]          i_word;
    logic                                 i_first;
    logic [dpsu_pkg::LEN_IN_W-1:0]        i_packet_words;
    logic                                 o_valid;
    logic                                 i_stall;
    logic                                 o_kind;
    logic [dpsu_pkg::CHAN_W-1:0]          o_channel;
    logic [dpsu_pkg::TIME_W-1:0]          o_time_bin;
    logic [dpsu_pkg::SAMPLE_W-1:0]        o_sample;
    logic [dpsu_pkg::LOW_W-1:0]           o_event_number;
    logic [dpsu_pkg::LOW_W-1:0]           o_module_address;
    logic [dpsu_pkg::LOW_W-1:0]           o_flag_word;
    logic [dpsu_pkg::LOW_W-1:0]           o_beam_clock;
    logic [dpsu_pkg::WORD_W-1:0]          o_user_word;
    logic                                 o_parity_ok;
    logic                                 o_end_of_packet;

    packet_scoreboard sb = new();

    logic [31:0] preset_words [$];
    int          words_sent  = 0;
    bit          sender_fast = 0;
    bit          held_off    = 0;
    int          stuck_cycles = 0;

    detector_packet_sparse_unpacker u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_word           (i_word),
        .i_first          (i_first),
        .i_packet_words   (i_packet_words),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_kind           (o_kind),
        .o_channel        (o_channel),
        .o_time_bin       (o_time_bin),
        .o_sample         (o_sample),
        .o_event_number   (o_event_number),
        .o_module_address (o_module_address),
        .o_flag_word      (o_flag_word),
        .o_beam_clock     (o_beam_clock),
        .o_user_word      (o_user_word),
        .o_parity_ok      (o_parity_ok),
        .o_end_of_packet  (o_end_of_packet)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // offer one beat and hold it until taken
    task automatic send_word(input logic [31:0] w, input logic f, input logic [12:0] plen);
        i_valid        <= 1'b1;
        i_word         <= w;
        i_first        <= f;
        i_packet_words <= plen;
        do @(posedge i_clk); while (o_stall);
    endtask

    // random gap between beats, mostly short
    task automatic sender_pause();
        int n;
        int r;
        if (sender_fast) return;
        r = $urandom_range(99);
        if (r < 55)      n = 0;
        else if (r < 85) n = $urandom_range(1, 3);
        else if (r < 97) n = $urandom_range(4, 12);
        else             n = $urandom_range(20, 60);
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // data word: random channel and time, some empty slots, rare end bit
    function automatic logic [31:0] make_data_word();
        logic [31:0] w;
        w = $urandom;
        for (int s = 0; s < dpsu_pkg::SLOTS; s++)
            if ($urandom_range(2) == 0) w[s*dpsu_pkg::SAMPLE_W +: dpsu_pkg::SAMPLE_W] = '0;
        w[dpsu_pkg::END_BIT] = ($urandom_range(15) == 0);
        return w;
    endfunction

    // send n_send words of a packet; preset words are used first, the parity
    // word is always computed so that it matches unless asked otherwise
    task automatic send_packet(input logic [12:0] plen, input int n_send, input bit bad_parity);
        int unsigned  eff;
        logic [19:0]  acc;
        logic [31:0]  w;
        eff = sb.clamp_length(plen);
        acc = '0;
        for (int p = 0; p < n_send; p++) begin
            if (p == eff - dpsu_pkg::PARITY_FROM_END) begin
                w = {12'h000, acc};
                if (bad_parity) w[$urandom_range(31)] ^= 1'b1;
            end else if (preset_words.size() != 0) begin
                w = preset_words.pop_front();
            end else if (p >= dpsu_pkg::DATA_FIRST_POS && p < eff - dpsu_pkg::USER_FROM_END) begin
                w = make_data_word();
            end else begin
                w = $urandom;
            end
            if (p <= eff - dpsu_pkg::USER_FROM_END) acc ^= w[19:0];
            send_word(w, p == 0, (p == 0) ? plen : 13'($urandom));
            words_sent++;
            sender_pause();
        end
    endtask

    // stimulus and end of run
    initial begin : stimulus
        int          sel;
        int          n;
        bit          at_rest;
        logic [12:0] plen;
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_word         <= '0;
        i_first        <= 1'b0;
        i_packet_words <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // stray word while idle
        send_word(32'hFFFF_FFFF, 1'b0, 13'h1FFF);
        sender_pause();

        // short packet, length below minimum, flag word doubles as user word
        preset_words = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hA5A5_A5A5};
        send_packet(13'd0, 6, 1'b1);

        // full hit word at the top channel and time, end bit, ignored data
        preset_words = '{32'h1234_5678, 32'h000F_FFFF, 32'hFFF0_0000, 32'h0000_0001,
                         32'h8000_0000, 32'h7FF0_FC3F, 32'h8000_0421, 32'h7FFF_FFFF,
                         32'hFFFF_FFFF};
        send_packet(13'd11, 11, 1'b0);

        // oversized length abandoned by a new first word
        send_packet(13'h1FFF, 3, 1'b0);
        send_packet(13'd5, 6, 1'b0);

        // random packets, mostly well formed
        at_rest = 1;
        while (words_sent < TARGET_WORDS) begin
            sel         = $urandom_range(99);
            sender_fast = ($urandom_range(9) == 0);
            if (sel < 8 && at_rest) begin
                n = $urandom_range(1, 3);
                repeat (n) begin
                    send_word($urandom, 1'b0, 13'($urandom));
                    sender_pause();
                end
            end else if (sel < 20) begin
                plen = 13'($urandom);
                n    = $urandom_range(1, 8);
                send_packet(plen, n, 1'b0);
                at_rest = (n >= sb.clamp_length(plen));
            end else begin
                sel = $urandom_range(99);
                if (sel < 80)      plen = 13'($urandom_range(6, 20));
                else if (sel < 95) plen = 13'($urandom_range(21, 100));
                else               plen = 13'($urandom_range(101, 200));
                send_packet(plen, sb.clamp_length(plen),
                            $urandom_range(4) == 0);
                at_rest = 1;
            end
        end

        sender_fast = 0;
        i_valid <= 1'b0;

        // drain
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // receiver back-pressure, with one long hold-off to fill the block
    initial begin : result_sink
        int n;
        int r;
        i_stall <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (!held_off && sb.checked >= 60) begin
                held_off = 1;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                r = $urandom_range(99);
                if (r < 10) begin
                    i_stall <= 1'b0;
                    n = $urandom_range(50, 150);
                end else if (r < 55) begin
                    i_stall <= 1'b0;
                    n = $urandom_range(1, 6);
                end else if (r < 92) begin
                    i_stall <= 1'b1;
                    n = $urandom_range(1, 3);
                end else begin
                    i_stall <= 1'b1;
                    n = $urandom_range(8, 40);
                end
                repeat (n) @(posedge i_clk);
            end
        end
    end

    // beat monitor: feed accepted words and check accepted results
    always @(posedge i_clk) begin : beat_monitor
        t_unpack_result got;
        if (i_rst_n && i_valid && !o_stall)
            sb.note_word(i_word, i_first, i_packet_words);
        if (i_rst_n && o_valid && !i_stall) begin
            got.kind           = o_kind;
            got.channel        = o_channel;
            got.time_bin       = o_time_bin;
            got.sample         = o_sample;
            got.event_number   = o_event_number;
            got.module_address = o_module_address;
            got.flag_word      = o_flag_word;
            got.beam_clock     = o_beam_clock;
            got.user_word      = o_user_word;
            got.parity_ok      = o_parity_ok;
            got.end_of_packet  = o_end_of_packet;
            sb.check_result(got);
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

endmodule
